### sv/usl_pkg.sv
`timescale 1ns / 1ps
// usl_pkg: types and constants for the unit vector slerp core
// no dependencies; used by usl_if.sv and unit_vector_slerp_core.sv
package usl_pkg;

  localparam int FracBits = 14;

  typedef logic signed [15:0] comp_t;
  typedef logic signed [31:0] prod_t;
  typedef logic signed [32:0] lprod_t;
  typedef logic signed [16:0] rel_t;
  typedef logic signed [34:0] cordic_t;
  typedef logic signed [50:0] fprod_t;
  typedef logic signed [21:0] rsum_t;

  localparam comp_t          OneQ       = 16'sd16384;
  localparam logic [14:0]    OneU       = 15'd16384;
  localparam logic [14:0]    NearThrRst = 15'd16220;
  localparam logic [28:0]    AmTop      = 29'd268435456;
  localparam cordic_t        HalfPiQ30  = 35'sd1686629713;
  localparam cordic_t        GainQ30    = 35'sd652032874;

  localparam logic [29:0] AtanQ30 [32] = '{
    30'd843314857, 30'd497837829, 30'd263043837, 30'd133525159, 30'd67021687,
    30'd33543516, 30'd16775851, 30'd8388437, 30'd4194283, 30'd2097149,
    30'd1048576, 30'd524288, 30'd262144, 30'd131072, 30'd65536, 30'd32768,
    30'd16384, 30'd8192, 30'd4096, 30'd2048, 30'd1024, 30'd512, 30'd256,
    30'd128, 30'd64, 30'd32, 30'd16, 30'd8, 30'd4, 30'd2, 30'd1, 30'd0
  };

  // everything a word carries down the pipeline
  typedef struct packed {
    comp_t [2:0]        f;
    comp_t [2:0]        t;
    logic  [14:0]       fr;
    prod_t [2:0]        pa;
    lprod_t [2:0]       lp;
    logic signed [19:0] dsum;
    comp_t              dot;
    logic               lin;
    comp_t [2:0]        lo;
    logic  [28:0]       dsq;
    logic  [28:0]       am;
    rel_t  [2:0]        r;
    logic  [2:0][32:0]  sqc;
    logic  [33:0]       lrem;
    logic  [16:0]       lroot;
    logic  [2:0][30:0]  drem;
    logic  [2:0][14:0]  q;
    comp_t [2:0]        o;
    logic  [60:0]       arem;
    logic  [30:0]       aroot;
    cordic_t            cx;
    cordic_t            cy;
    cordic_t            cz;
    logic  [46:0]       pang;
    fprod_t [2:0]       pf;
    fprod_t [2:0]       po;
    rsum_t [2:0]        rs;
    comp_t [2:0]        res;
  } item_t;

  function automatic comp_t sat_one(input rsum_t v);
    if (v > 22'sd16384) begin
      return OneQ;
    end
    if (v < -22'sd16384) begin
      return -OneQ;
    end
    return v[15:0];
  endfunction

endpackage

### sv/usl_if.sv
`timescale 1ns / 1ps
// usl_in_if, usl_out_if: valid/ready channels of the slerp core
// depends on usl_pkg
interface usl_in_if;
  import usl_pkg::*;
  logic        valid;
  logic        ready;
  comp_t       from_x;
  comp_t       from_y;
  comp_t       from_z;
  comp_t       to_x;
  comp_t       to_y;
  comp_t       to_z;
  logic [14:0] fraction;

  modport source (output valid, from_x, from_y, from_z, to_x, to_y, to_z, fraction,
                  input ready);
  modport sink (input valid, from_x, from_y, from_z, to_x, to_y, to_z, fraction,
                output ready);
endinterface

interface usl_out_if;
  import usl_pkg::*;
  logic  valid;
  logic  ready;
  comp_t out_x;
  comp_t out_y;
  comp_t out_z;
  logic  used_linear;

  modport source (output valid, out_x, out_y, out_z, used_linear, input ready);
  modport sink (input valid, out_x, out_y, out_z, used_linear, output ready);
endinterface

### sv/unit_vector_slerp_core.sv
`timescale 1ns / 1ps
// unit_vector_slerp_core: fully pipelined fixed-point slerp of two unit 3-vectors
// depends on usl_pkg and the channel interfaces in usl_if.sv
//
// channel     dir   handshake       payload
// item_i      in    valid/ready     from_x/y/z, to_x/y/z, fraction (Q1.14)
// result_o    out   valid/ready     out_x/y/z (Q2.14), used_linear
// cfg         in    cfg_we_i        cfg_wdata_i -> near_threshold
//
// one word enters per cycle while result_o is not stalled; the pipeline depth is set by the
// two bit-serial square roots, the 15-step divider and the two CORDIC chains
// reset clears the stage valid bits and loads near_threshold with 16220
// a stall on result_o freezes every stage; item_i.ready drops in the same cycle
// the last stage is the output register, so no word is dropped or repeated
module unit_vector_slerp_core #(
  parameter int CORDIC_STEPS = 16
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               cfg_we_i,
  input  logic [14:0]        cfg_wdata_i,
  usl_in_if.sink             item_i,
  usl_out_if.source          result_o
);
  import usl_pkg::*;

  localparam int LsqN    = 17;
  localparam int DivN    = 15;
  localparam int AsqN    = 31;
  localparam int SMul0   = 0;
  localparam int SDsum   = 1;
  localparam int SDot    = 2;
  localparam int SFdot   = 3;
  localparam int SRel    = 4;
  localparam int SSqr    = 5;
  localparam int SSsq    = 6;
  localparam int SLsq    = 7;
  localparam int SDinit  = SLsq + LsqN;
  localparam int SDiv    = SDinit + 1;
  localparam int SOrth   = SDiv + DivN;
  localparam int SAsq    = SOrth + 1;
  localparam int SVinit  = SAsq + AsqN;
  localparam int SVec    = SVinit + 1;
  localparam int SAfin   = SVec + CORDIC_STEPS;
  localparam int SAmul   = SAfin + 1;
  localparam int SArnd   = SAmul + 1;
  localparam int SRinit  = SArnd + 1;
  localparam int SRot    = SRinit + 1;
  localparam int SFprod  = SRot + CORDIC_STEPS;
  localparam int SFsum   = SFprod + 1;
  localparam int SFout   = SFsum + 1;
  localparam int NStg    = SFout + 1;

  logic [14:0]     thr_q;
  logic [NStg-1:0] vld_q;
  item_t           st_q [NStg];
  item_t           st_d [NStg];
  logic            adv;

  assign adv          = !vld_q[NStg-1] || result_o.ready;
  assign item_i.ready = adv;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      thr_q <= NearThrRst;
      vld_q <= '0;
    end else begin
      if (cfg_we_i) begin
        thr_q <= cfg_wdata_i;
      end
      if (adv) begin
        vld_q <= {vld_q[NStg-2:0], item_i.valid};
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      st_q <= st_d;
    end
  end

  // products for the dot and the linear path
  always_comb begin
    item_t it;
    rel_t  dd;
    it      = '0;
    it.f[0] = item_i.from_x;
    it.f[1] = item_i.from_y;
    it.f[2] = item_i.from_z;
    it.t[0] = item_i.to_x;
    it.t[1] = item_i.to_y;
    it.t[2] = item_i.to_z;
    it.fr   = (item_i.fraction > OneU) ? OneU : item_i.fraction;
    for (int c = 0; c < 3; c++) begin
      dd       = 17'(it.t[c]) - 17'(it.f[c]);
      it.pa[c] = it.f[c] * it.t[c];
      it.lp[c] = dd * $signed({1'b0, it.fr});
    end
    st_d[SMul0] = it;
  end

  always_comb begin
    item_t              it;
    logic signed [33:0] sum;
    rsum_t              v;
    it      = st_q[SDsum-1];
    sum     = 34'(it.pa[0]) + 34'(it.pa[1]) + 34'(it.pa[2]);
    it.dsum = 20'((sum + 34'sd8192) >>> FracBits);
    for (int c = 0; c < 3; c++) begin
      v        = 22'(it.f[c]) + 22'((it.lp[c] + 33'sd8192) >>> FracBits);
      it.lo[c] = sat_one(v);
    end
    st_d[SDsum] = it;
  end

  always_comb begin
    item_t       it;
    logic [15:0] mag;
    it = st_q[SDot-1];
    if (it.dsum > 20'sd16384) begin
      it.dot = OneQ;
    end else if (it.dsum < -20'sd16384) begin
      it.dot = -OneQ;
    end else begin
      it.dot = it.dsum[15:0];
    end
    mag        = (it.dot < 0) ? -it.dot : it.dot;
    it.lin     = mag > {1'b0, thr_q};
    st_d[SDot] = it;
  end

  always_comb begin
    item_t it;
    prod_t pd;
    it     = st_q[SFdot-1];
    pd     = it.dot * it.dot;
    it.dsq = pd[28:0];
    for (int c = 0; c < 3; c++) begin
      it.pa[c] = it.f[c] * it.dot;
    end
    st_d[SFdot] = it;
  end

  // part of the target orthogonal to the source
  always_comb begin
    item_t it;
    it    = st_q[SRel-1];
    it.am = AmTop - it.dsq;
    for (int c = 0; c < 3; c++) begin
      it.r[c] = 17'(it.t[c]) - 17'((it.pa[c] + 32'sd8192) >>> FracBits);
    end
    st_d[SRel] = it;
  end

  always_comb begin
    item_t              it;
    logic signed [33:0] p;
    it = st_q[SSqr-1];
    for (int c = 0; c < 3; c++) begin
      p         = it.r[c] * it.r[c];
      it.sqc[c] = p[32:0];
    end
    st_d[SSqr] = it;
  end

  always_comb begin
    item_t it;
    it          = st_q[SSsq-1];
    it.lrem     = 34'(it.sqc[0]) + 34'(it.sqc[1]) + 34'(it.sqc[2]);
    it.lroot    = '0;
    st_d[SSsq]  = it;
  end

  // length: one root bit per stage
  for (genvar k = 0; k < LsqN; k++) begin : g_lsq
    localparam int B = LsqN - 1 - k;
    always_comb begin
      item_t       it;
      logic [34:0] trial;
      it    = st_q[SLsq+k-1];
      trial = (35'(it.lroot) << (B + 1)) + (35'd1 << (2 * B));
      if ({1'b0, it.lrem} >= trial) begin
        it.lrem     = it.lrem - trial[33:0];
        it.lroot[B] = 1'b1;
      end
      st_d[SLsq+k] = it;
    end
  end

  always_comb begin
    item_t       it;
    logic [16:0] ab;
    it = st_q[SDinit-1];
    for (int c = 0; c < 3; c++) begin
      ab         = (it.r[c] < 0) ? 17'(-it.r[c]) : 17'(it.r[c]);
      it.drem[c] = {ab, 14'd0} + 31'(it.lroot[16:1]);
      it.q[c]    = '0;
    end
    st_d[SDinit] = it;
  end

  // rounded divide by the length, one quotient bit per stage
  for (genvar k = 0; k < DivN; k++) begin : g_div
    localparam int B = DivN - 1 - k;
    always_comb begin
      item_t       it;
      logic [31:0] dv;
      it = st_q[SDiv+k-1];
      dv = 32'(it.lroot) << B;
      for (int c = 0; c < 3; c++) begin
        if (32'(it.drem[c]) >= dv) begin
          it.drem[c]    = it.drem[c] - dv[30:0];
          it.q[c][B]    = 1'b1;
        end
      end
      st_d[SDiv+k] = it;
    end
  end

  always_comb begin
    item_t       it;
    logic [14:0] qc;
    it = st_q[SOrth-1];
    for (int c = 0; c < 3; c++) begin
      if (it.lroot == '0) begin
        qc = '0;
      end else begin
        qc = (it.q[c] > OneU) ? OneU : it.q[c];
      end
      it.o[c] = (it.r[c] < 0) ? -16'(qc) : 16'(qc);
    end
    it.arem     = {it.am, 32'd0};
    it.aroot    = '0;
    st_d[SOrth] = it;
  end

  // sqrt(1 - dot^2) in Q30
  for (genvar k = 0; k < AsqN; k++) begin : g_asq
    localparam int B = AsqN - 1 - k;
    always_comb begin
      item_t       it;
      logic [61:0] trial;
      it    = st_q[SAsq+k-1];
      trial = (62'(it.aroot) << (B + 1)) + (62'd1 << (2 * B));
      if ({1'b0, it.arem} >= trial) begin
        it.arem     = it.arem - trial[60:0];
        it.aroot[B] = 1'b1;
      end
      st_d[SAsq+k] = it;
    end
  end

  always_comb begin
    item_t it;
    it           = st_q[SVinit-1];
    it.cx        = 35'(it.aroot);
    it.cy        = -(35'(it.dot) <<< 16);
    it.cz        = '0;
    st_d[SVinit] = it;
  end

  // vectoring cordic drives y to zero, z collects the angle
  for (genvar k = 0; k < CORDIC_STEPS; k++) begin : g_vec
    always_comb begin
      item_t   it;
      cordic_t nx;
      cordic_t ny;
      it = st_q[SVec+k-1];
      if (it.cy > 0) begin
        nx    = it.cx + (it.cy >>> k);
        ny    = it.cy - (it.cx >>> k);
        it.cz = it.cz + 35'(AtanQ30[k]);
      end else begin
        nx    = it.cx - (it.cy >>> k);
        ny    = it.cy + (it.cx >>> k);
        it.cz = it.cz - 35'(AtanQ30[k]);
      end
      it.cx        = nx;
      it.cy        = ny;
      st_d[SVec+k] = it;
    end
  end

  always_comb begin
    item_t   it;
    cordic_t z;
    it          = st_q[SAfin-1];
    z           = it.cz + HalfPiQ30;
    it.cz       = (z < 0) ? '0 : z;
    st_d[SAfin] = it;
  end

  always_comb begin
    item_t it;
    it          = st_q[SAmul-1];
    it.pang     = 47'(it.cz[31:0]) * 47'(it.fr);
    st_d[SAmul] = it;
  end

  always_comb begin
    item_t it;
    it          = st_q[SArnd-1];
    it.cz       = 35'((it.pang + 47'd8192) >> FracBits);
    st_d[SArnd] = it;
  end

  // past a quarter turn start from (0, gain)
  always_comb begin
    item_t it;
    it = st_q[SRinit-1];
    if (it.cz > HalfPiQ30) begin
      it.cx = '0;
      it.cy = GainQ30;
      it.cz = it.cz - HalfPiQ30;
    end else begin
      it.cx = GainQ30;
      it.cy = '0;
    end
    st_d[SRinit] = it;
  end

  for (genvar k = 0; k < CORDIC_STEPS; k++) begin : g_rot
    always_comb begin
      item_t   it;
      cordic_t nx;
      cordic_t ny;
      it = st_q[SRot+k-1];
      if (it.cz >= 0) begin
        nx    = it.cx - (it.cy >>> k);
        ny    = it.cy + (it.cx >>> k);
        it.cz = it.cz - 35'(AtanQ30[k]);
      end else begin
        nx    = it.cx + (it.cy >>> k);
        ny    = it.cy - (it.cx >>> k);
        it.cz = it.cz + 35'(AtanQ30[k]);
      end
      it.cx        = nx;
      it.cy        = ny;
      st_d[SRot+k] = it;
    end
  end

  always_comb begin
    item_t it;
    it = st_q[SFprod-1];
    for (int c = 0; c < 3; c++) begin
      it.pf[c] = it.f[c] * it.cx;
      it.po[c] = it.o[c] * it.cy;
    end
    st_d[SFprod] = it;
  end

  always_comb begin
    item_t it;
    it = st_q[SFsum-1];
    for (int c = 0; c < 3; c++) begin
      it.rs[c] = 22'((52'(it.pf[c]) + 52'(it.po[c]) + 52'sd536870912) >>> 30);
    end
    st_d[SFsum] = it;
  end

  always_comb begin
    item_t it;
    it = st_q[SFout-1];
    for (int c = 0; c < 3; c++) begin
      it.res[c] = it.lin ? it.lo[c] : sat_one(it.rs[c]);
    end
    st_d[SFout] = it;
  end

  assign result_o.valid       = vld_q[NStg-1];
  assign result_o.out_x       = st_q[NStg-1].res[0];
  assign result_o.out_y       = st_q[NStg-1].res[1];
  assign result_o.out_z       = st_q[NStg-1].res[2];
  assign result_o.used_linear = st_q[NStg-1].lin;

`ifndef ASSERT_OFF
  a_freeze: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !adv |=> $stable(vld_q))
    else $error("stage valid bits moved during a stall");

  a_len_floor: assert property (@(posedge clk_i) disable iff (!rst_ni)
    vld_q[SDinit-1] |->
      35'(st_q[SDinit-1].lrem) <= (35'(st_q[SDinit-1].lroot) << 1))
    else $error("length root is not the floor square root");

  a_quot_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    vld_q[SOrth-1] && st_q[SOrth-1].lroot != '0 |->
      st_q[SOrth-1].q[0] <= OneU && st_q[SOrth-1].q[1] <= OneU &&
      st_q[SOrth-1].q[2] <= OneU)
    else $error("normalized component above one");

  a_out_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    result_o.valid |->
      result_o.out_x <= OneQ && result_o.out_x >= -OneQ &&
      result_o.out_y <= OneQ && result_o.out_y >= -OneQ &&
      result_o.out_z <= OneQ && result_o.out_z >= -OneQ)
    else $error("result component outside plus or minus one");
`endif

endmodule

### tb/tb_unit_vector_slerp_core.sv
`timescale 1ns / 1ps
// tb_unit_vector_slerp_core: self-checking bench for the pipelined slerp core
// depends on usl_pkg, usl_if.sv and unit_vector_slerp_core.sv
module tb_unit_vector_slerp_core;
  import usl_pkg::*;

  localparam int NumSteps    = 16;
  localparam int IdleLimit   = 3000;
  localparam int HoldCycles  = 400;
  localparam int TailCycles  = 150;
  localparam int PhaseWords  = 78;
  // more words than the pipeline holds, so the long hold-off backs up the input
  localparam int PressWords  = 160;
  localparam logic [14:0] ThrMax = 15'h7FFF;

  typedef struct {
    comp_t       fx, fy, fz, tx, ty, tz;
    logic [14:0] fr;
  } pair_t;

  typedef struct {
    comp_t x, y, z;
    logic  lin;
  } arc_t;

  typedef struct {
    comp_t       fx, fy, fz, tx, ty, tz;
    logic [14:0] fr;
    bit          typed;
    comp_t       ex, ey, ez;
    logic        el;
  } row_t;

  logic        clk;
  logic        rst_n;
  logic        cfg_we;
  logic [14:0] cfg_wdata;

  usl_in_if  in_ch ();
  usl_out_if out_ch ();

  unit_vector_slerp_core #(.CORDIC_STEPS(NumSteps)) DUT (
    .clk_i       (clk),
    .rst_ni      (rst_n),
    .cfg_we_i    (cfg_we),
    .cfg_wdata_i (cfg_wdata),
    .item_i      (in_ch),
    .result_o    (out_ch)
  );

  logic [14:0] near_thr;
  arc_t        arc_q[$];
  int          errors;
  int          checked;
  int          lin_seen;
  bit          no_gaps;
  bit          hold_req;

  longint atan_tab[NumSteps] = '{
    843314857, 497837829, 263043837, 133525159, 67021687, 33543516,
    16775851, 8388437, 4194283, 2097149, 1048576, 524288, 262144, 131072,
    65536, 32768
  };

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  function automatic longint rnd_sh(input longint v, input int s);
    return (v + (longint'(1) <<< (s - 1))) >>> s;
  endfunction

  function automatic longint sat_q(input longint v);
    if (v > 16384) begin
      return 16384;
    end
    if (v < -16384) begin
      return -16384;
    end
    return v;
  endfunction

  function automatic longint unsigned int_sqrt(input longint unsigned v);
    longint unsigned res, bitv;
    res = 0;
    bitv = 64'd1 << 62;
    while (bitv > v) bitv = bitv >> 2;
    while (bitv != 0) begin
      if (v >= res + bitv) begin
        v = v - (res + bitv);
        res = (res >> 1) + bitv;
      end else begin
        res = res >> 1;
      end
      bitv = bitv >> 2;
    end
    return res;
  endfunction

  // vectoring cordic on (sqrt(1-d^2), -d), plus pi/2
  function automatic longint arc_cos(input longint dot);
    longint d30, x, y, z, nx;
    d30 = dot * 65536;
    x = longint'(int_sqrt(longint'(64'd1 << 60) - d30 * d30));
    y = -d30;
    z = 0;
    for (int i = 0; i < NumSteps; i++) begin
      if (y > 0) begin
        nx = x + (y >>> i);
        y = y - (x >>> i);
        z = z + atan_tab[i];
      end else begin
        nx = x - (y >>> i);
        y = y + (x >>> i);
        z = z - atan_tab[i];
      end
      x = nx;
    end
    z = z + 1686629713;
    return (z < 0) ? 0 : z;
  endfunction

  function automatic void rotate(input longint ang, output longint c, output longint s);
    longint x, y, z, nx;
    x = 652032874;
    y = 0;
    z = ang;
    if (ang > 1686629713) begin
      x = 0;
      y = 652032874;
      z = ang - 1686629713;
    end
    for (int i = 0; i < NumSteps; i++) begin
      if (z >= 0) begin
        nx = x - (y >>> i);
        y = y + (x >>> i);
        z = z - atan_tab[i];
      end else begin
        nx = x + (y >>> i);
        y = y - (x >>> i);
        z = z + atan_tab[i];
      end
      x = nx;
    end
    c = x;
    s = y;
  endfunction

  function automatic arc_t slerp_predict(input pair_t p, input logic [14:0] thr);
    longint f[3], t[3], r[3], o[3];
    longint fr, dot, mag, ang, cs, sn, a, q;
    longint unsigned len;
    arc_t res;
    f = '{p.fx, p.fy, p.fz};
    t = '{p.tx, p.ty, p.tz};
    fr = (p.fr > 16384) ? 16384 : p.fr;
    dot = rnd_sh(f[0] * t[0] + f[1] * t[1] + f[2] * t[2], 14);
    if (dot > 16384) dot = 16384;
    if (dot < -16384) dot = -16384;
    mag = (dot < 0) ? -dot : dot;
    res.lin = (mag > longint'(thr));
    if (res.lin) begin
      for (int i = 0; i < 3; i++) o[i] = sat_q(f[i] + rnd_sh((t[i] - f[i]) * fr, 14));
    end else begin
      for (int i = 0; i < 3; i++) r[i] = t[i] - rnd_sh(f[i] * dot, 14);
      len = int_sqrt(r[0] * r[0] + r[1] * r[1] + r[2] * r[2]);
      for (int i = 0; i < 3; i++) begin
        a = (r[i] < 0) ? -r[i] : r[i];
        q = 0;
        if (len != 0) begin
          q = (a * 16384 + longint'(len / 2)) / longint'(len);
          if (q > 16384) q = 16384;
        end
        r[i] = (r[i] < 0) ? -q : q;
      end
      ang = rnd_sh(arc_cos(dot) * fr, 14);
      rotate(ang, cs, sn);
      for (int i = 0; i < 3; i++) o[i] = sat_q(rnd_sh(f[i] * cs + r[i] * sn, 30));
    end
    res.x = comp_t'(o[0]);
    res.y = comp_t'(o[1]);
    res.z = comp_t'(o[2]);
    return res;
  endfunction

  // offer one word after an optional gap, return once it is taken
  task automatic send_word(input pair_t p, input arc_t want);
    int gap, r;
    r = $urandom_range(0, 19);
    gap = no_gaps ? 0 : (r < 12) ? 0 : (r < 18) ? $urandom_range(1, 3) : $urandom_range(10, 40);
    if (gap > 0) begin
      in_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_ch.valid    <= 1'b1;
    in_ch.from_x   <= p.fx;
    in_ch.from_y   <= p.fy;
    in_ch.from_z   <= p.fz;
    in_ch.to_x     <= p.tx;
    in_ch.to_y     <= p.ty;
    in_ch.to_z     <= p.tz;
    in_ch.fraction <= p.fr;
    do @(posedge clk); while (!in_ch.ready);
    arc_q.push_back(want);
  endtask

  task automatic drain();
    while (arc_q.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_thr(input logic [14:0] v);
    cfg_we    <= 1'b1;
    cfg_wdata <= v;
    @(posedge clk);
    cfg_we    <= 1'b0;
    near_thr = v;
  endtask

  function automatic comp_t rand_comp();
    return comp_t'(int'($urandom_range(0, 32768)) - 16384);
  endfunction

  function automatic comp_t clip_comp(input int v);
    return comp_t'((v > 16384) ? 16384 : (v < -16384) ? -16384 : v);
  endfunction

  function automatic void unit_dir(output comp_t x, output comp_t y, output comp_t z);
    real gx, gy, gz, n;
    gx = real'(int'($urandom_range(0, 2000)) - 1000);
    gy = real'(int'($urandom_range(0, 2000)) - 1000);
    gz = real'(int'($urandom_range(0, 2000)) - 1000);
    n = $sqrt(gx * gx + gy * gy + gz * gz);
    if (n == 0.0) begin
      gx = 1.0;
      n = 1.0;
    end
    x = comp_t'($rtoi(gx / n * 16384.0));
    y = comp_t'($rtoi(gy / n * 16384.0));
    z = comp_t'($rtoi(gz / n * 16384.0));
  endfunction

  function automatic pair_t rand_pair();
    pair_t p;
    int kind, w;
    kind = $urandom_range(0, 9);
    unit_dir(p.fx, p.fy, p.fz);
    if (kind < 5) begin
      unit_dir(p.tx, p.ty, p.tz);
    end else if (kind < 8) begin
      // close to the source or its opposite, to exercise the threshold
      w = $urandom_range(0, 1) ? 1 : -1;
      p.tx = clip_comp(w * p.fx + int'($urandom_range(0, 600)) - 300);
      p.ty = clip_comp(w * p.fy + int'($urandom_range(0, 600)) - 300);
      p.tz = clip_comp(w * p.fz + int'($urandom_range(0, 600)) - 300);
    end else begin
      p.fx = rand_comp();
      p.fy = rand_comp();
      p.fz = rand_comp();
      p.tx = rand_comp();
      p.ty = rand_comp();
      p.tz = rand_comp();
    end
    p.fr = ($urandom_range(0, 9) == 0) ? 15'($urandom_range(0, 32767))
                                       : 15'($urandom_range(0, 16384));
    return p;
  endfunction

  // result checker
  always @(posedge clk) begin
    arc_t want;
    if (rst_n && out_ch.valid && out_ch.ready) begin
      if (arc_q.size() == 0) begin
        errors++;
        $display("%0t: unexpected word x=%0d y=%0d z=%0d lin=%0b", $time,
                 out_ch.out_x, out_ch.out_y, out_ch.out_z, out_ch.used_linear);
      end else begin
        want = arc_q.pop_front();
        checked++;
        if (out_ch.used_linear) lin_seen++;
        if (out_ch.out_x !== want.x || out_ch.out_y !== want.y ||
            out_ch.out_z !== want.z || out_ch.used_linear !== want.lin) begin
          errors++;
          $display("%0t: mismatch expected x=%0d y=%0d z=%0d lin=%0b", $time,
                   want.x, want.y, want.z, want.lin);
          $display("%0t:          actual   x=%0d y=%0d z=%0d lin=%0b", $time,
                   out_ch.out_x, out_ch.out_y, out_ch.out_z, out_ch.used_linear);
        end
      end
    end
  end

  // receiver: random stalls, one long hold-off on request
  initial begin
    int stall, hold;
    stall = 0;
    hold = 0;
    out_ch.ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (hold_req && hold == 0) begin
        hold = HoldCycles;
        hold_req = 1'b0;
      end
      if (hold > 0) begin
        hold--;
        out_ch.ready <= 1'b0;
      end else if (stall > 0) begin
        stall--;
        out_ch.ready <= 1'b0;
      end else if (!no_gaps && $urandom_range(0, 5) == 0) begin
        stall = ($urandom_range(0, 9) == 0) ? $urandom_range(15, 50) : $urandom_range(0, 2);
        out_ch.ready <= 1'b0;
      end else begin
        out_ch.ready <= 1'b1;
      end
    end
  end

  initial begin
    int quiet;
    quiet = 0;
    forever begin
      @(posedge clk);
      if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready)) quiet = 0;
      else quiet++;
      if (quiet >= IdleLimit) begin
        $display("tb: failure");
        $finish;
      end
    end
  end

  initial begin
    row_t        tab[12];
    logic [14:0] thr_list[6];
    pair_t       p;
    arc_t        want;
    errors = 0;
    checked = 0;
    lin_seen = 0;
    no_gaps = 1'b0;
    hold_req = 1'b0;
    near_thr = NearThrRst;
    rst_n <= 1'b0;
    cfg_we <= 1'b0;
    cfg_wdata <= '0;
    in_ch.valid <= 1'b0;
    in_ch.from_x <= '0;
    in_ch.from_y <= '0;
    in_ch.from_z <= '0;
    in_ch.to_x <= '0;
    in_ch.to_y <= '0;
    in_ch.to_z <= '0;
    in_ch.fraction <= '0;
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    tab = '{
      '{16384, 0, 0, 16384, 0, 0, 15'd0, 1, 16384, 0, 0, 1'b1},
      '{16384, 0, 0, -16384, 0, 0, 15'd16384, 1, -16384, 0, 0, 1'b1},
      // clamped dot, fraction above one
      '{-16384, -16384, -16384, 16384, 16384, 16384, 15'h7FFF, 1, 16384, 16384, 16384, 1'b1},
      // no orthogonal part left
      '{0, 0, 0, 0, 0, 0, 15'd16384, 1, 0, 0, 0, 1'b0},
      '{16384, 0, 0, 16384, 0, 0, 15'd8192, 1, 16384, 0, 0, 1'b1},
      '{0, 16384, 0, 0, 0, -16384, 15'd0, 0, 0, 0, 0, 1'b0},
      '{16384, 0, 0, 0, 16384, 0, 15'd8192, 0, 0, 0, 0, 1'b0},
      '{16384, 0, 0, 0, 16384, 0, 15'd16384, 0, 0, 0, 0, 1'b0},
      '{-1, 0, -16384, 16384, -1, 0, 15'h5555, 0, 0, 0, 0, 1'b0},
      '{16384, 16384, 0, 0, -16384, 16384, 15'h2AAA, 0, 0, 0, 0, 1'b0},
      '{0, 0, -16384, 11585, 0, 11585, 15'd16385, 0, 0, 0, 0, 1'b0},
      '{-16384, 0, 0, 0, 0, 16384, 15'd1, 0, 0, 0, 0, 1'b0}
    };
    foreach (tab[i]) begin
      p = '{tab[i].fx, tab[i].fy, tab[i].fz, tab[i].tx, tab[i].ty, tab[i].tz, tab[i].fr};
      if (tab[i].typed) want = '{tab[i].ex, tab[i].ey, tab[i].ez, tab[i].el};
      else want = slerp_predict(p, near_thr);
      send_word(p, want);
    end
    in_ch.valid <= 1'b0;
    drain();

    thr_list = '{NearThrRst, 15'd0, OneU, ThrMax, 15'($urandom_range(15000, 16384)), NearThrRst};
    foreach (thr_list[ph]) begin
      if (ph > 0) write_thr(thr_list[ph]);
      no_gaps = (ph == 2 || ph == 4);
      if (ph == 2) hold_req = 1'b1;
      repeat ((ph == 2) ? PressWords : PhaseWords) begin
        p = rand_pair();
        send_word(p, slerp_predict(p, near_thr));
      end
      in_ch.valid <= 1'b0;
      drain();
    end

    repeat (TailCycles) @(posedge clk);
    $display("tb: %0d words checked, %0d via linear fallback", checked, lin_seen);
    $display("tb: thresholds 0 to 32767 swept, long output stall with input backpressure");
    if (errors == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule
